// ===== hw/rtl/fpg_pkg.sv =====
package fpg_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned HASH_W  = 32;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [HASH_W-1:0] FNV_OFFSET = 32'd2166136261;
   localparam logic [HASH_W-1:0] FNV_PRIME  = 32'd16777619;

   localparam logic [CSR_IDX_W-1:0] CSR_SINK_PRESENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAW_MODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_ALIVE   = 2'd3;

   typedef enum logic [2:0] {
      VERDICT_PUSH   = 3'd0,
      VERDICT_RATE   = 3'd1,
      VERDICT_CLEAN  = 3'd2,
      VERDICT_SAME   = 3'd3,
      VERDICT_NOSINK = 3'd4
   } verdict_type;

   typedef struct packed {
      logic              sink_present;
      logic              draw_mode;
      logic [TIME_W-1:0] min_frame_interval_ms;
      logic [TIME_W-1:0] keep_alive_ms;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_byte;
      logic              first_byte;
      logic              last_byte;
      logic [TIME_W-1:0] now_ms;
      logic              canvas_dirty;
   } req_item_type;

   typedef struct packed {
      verdict_type        decision;
      logic               clear_dirty;
      logic [HASH_W-1:0]  frame_hash;
      logic [COUNT_W-1:0] push_total;
   } rsp_item_type;

   // Outcome of the checks made on the first byte of a frame.
   typedef struct packed {
      verdict_type verdict;
      logic        keep_alive_due;
      logic        considered;
   } judge_type;

   // History that the first-byte checks look at.
   typedef struct packed {
      logic              considered_once;
      logic [TIME_W-1:0] last_considered_ms;
      logic              pushed_once;
      logic [TIME_W-1:0] last_pushed_ms;
   } history_type;

endpackage

// ===== hw/rtl/fpg_req_if.sv =====
interface fpg_req_if;
   import fpg_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] pixel_byte;
   logic              first_byte;
   logic              last_byte;
   logic [TIME_W-1:0] now_ms;
   logic              canvas_dirty;

   modport source (
      output valid, pixel_byte, first_byte, last_byte, now_ms, canvas_dirty,
      input  ready
   );

   modport sink (
      input  valid, pixel_byte, first_byte, last_byte, now_ms, canvas_dirty,
      output ready
   );

endinterface

// ===== hw/rtl/fpg_rsp_if.sv =====
interface fpg_rsp_if;
   import fpg_pkg::*;

   logic               valid;
   logic               ready;
   logic [2:0]         decision;
   logic               clear_dirty;
   logic [HASH_W-1:0]  frame_hash;
   logic [COUNT_W-1:0] push_total;

   modport source (
      output valid, decision, clear_dirty, frame_hash, push_total,
      input  ready
   );

   modport sink (
      input  valid, decision, clear_dirty, frame_hash, push_total,
      output ready
   );

endinterface

// ===== hw/rtl/fpg_csr.sv =====
module fpg_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [fpg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fpg_pkg::CSR_DATA_W-1:0]    csr_data,
   output fpg_pkg::cfg_type                  cfg
);
   import fpg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SINK_PRESENT: cfg_in.sink_present          = csr_data[0];
            CSR_DRAW_MODE:    cfg_in.draw_mode             = csr_data[0];
            CSR_MIN_INTERVAL: cfg_in.min_frame_interval_ms = csr_data[TIME_W-1:0];
            CSR_KEEP_ALIVE:   cfg_in.keep_alive_ms         = csr_data[TIME_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/fpg_judge.sv =====
module fpg_judge (
   input  fpg_pkg::cfg_type                cfg,
   input  fpg_pkg::history_type            hist,
   input  logic [fpg_pkg::TIME_W-1:0]      now_ms,
   input  logic                            canvas_dirty,
   output fpg_pkg::judge_type              judge
);
   import fpg_pkg::*;

   logic [TIME_W-1:0] since_push;
   logic [TIME_W-1:0] since_considered;
   logic              keep_alive;

   // Differences wrap modulo 2^32 on purpose.
   assign since_push       = now_ms - hist.last_pushed_ms;
   assign since_considered = now_ms - hist.last_considered_ms;
   assign keep_alive       = hist.pushed_once && (cfg.keep_alive_ms != '0) &&
                             (since_push >= cfg.keep_alive_ms);

   always_comb begin
      judge.verdict        = VERDICT_NOSINK;
      judge.keep_alive_due = 1'b0;
      judge.considered     = 1'b0;
      if (cfg.sink_present) begin
         judge.keep_alive_due = keep_alive;
         if (hist.considered_once && (since_considered < cfg.min_frame_interval_ms)) begin
            judge.verdict = VERDICT_RATE;
         end else begin
            judge.considered = 1'b1;
            if (!cfg.draw_mode && hist.pushed_once && !canvas_dirty && !keep_alive) begin
               judge.verdict = VERDICT_CLEAN;
            end else begin
               judge.verdict = VERDICT_PUSH;
            end
         end
      end
   end

endmodule

// ===== hw/rtl/fpg_core.sv =====
module fpg_core (
   input  logic                   clock,
   input  logic                   reset,
   input  fpg_pkg::cfg_type       cfg,
   input  fpg_pkg::req_item_type  item,
   input  logic                   step_en,
   output logic                   emit,
   output fpg_pkg::rsp_item_type  result
);
   import fpg_pkg::*;

   logic               frame_active_ff, frame_active_in;
   logic [HASH_W-1:0]  running_hash_ff, running_hash_in;
   verdict_type        verdict_ff, verdict_in;
   logic               keep_alive_due_ff, keep_alive_due_in;
   history_type        hist_ff, hist_in;
   logic [HASH_W-1:0]  last_hash_ff, last_hash_in;
   logic [COUNT_W-1:0] push_count_ff, push_count_in;

   judge_type          judge;
   logic               active;
   logic               step;
   logic [HASH_W-1:0]  hash_base;
   logic [HASH_W-1:0]  hash_next;
   verdict_type        cur_verdict;
   logic               cur_keep_alive;
   logic               same_content;
   logic               do_push;

   fpg_judge u_judge (
      .cfg          (cfg),
      .hist         (hist_ff),
      .now_ms       (item.now_ms),
      .canvas_dirty (item.canvas_dirty),
      .judge        (judge)
   );

   assign active = item.first_byte || frame_active_ff;
   assign emit   = active && item.last_byte;
   assign step   = step_en && active;

   assign hash_base = item.first_byte ? FNV_OFFSET : running_hash_ff;
   assign hash_next = (hash_base ^ {{(HASH_W-BYTE_W){1'b0}}, item.pixel_byte}) * FNV_PRIME;

   assign cur_verdict    = item.first_byte ? judge.verdict : verdict_ff;
   assign cur_keep_alive = item.first_byte ? judge.keep_alive_due : keep_alive_due_ff;
   assign same_content   = hist_ff.pushed_once && (hash_next == last_hash_ff) &&
                           !cur_keep_alive;
   assign do_push        = step && item.last_byte && (cur_verdict == VERDICT_PUSH) &&
                           !same_content;

   always_comb begin
      frame_active_in   = frame_active_ff;
      running_hash_in   = running_hash_ff;
      verdict_in        = verdict_ff;
      keep_alive_due_in = keep_alive_due_ff;
      hist_in           = hist_ff;
      last_hash_in      = last_hash_ff;
      push_count_in     = push_count_ff;
      if (step) begin
         frame_active_in = !item.last_byte;
         running_hash_in = hash_next;
         if (item.first_byte) begin
            verdict_in        = judge.verdict;
            keep_alive_due_in = judge.keep_alive_due;
            if (judge.considered) begin
               hist_in.considered_once    = 1'b1;
               hist_in.last_considered_ms = item.now_ms;
            end
         end
      end
      if (do_push) begin
         // A pushed frame was considered on its own first byte, so the
         // considered time stamp is the one of this frame.
         last_hash_in           = hash_next;
         hist_in.pushed_once    = 1'b1;
         hist_in.last_pushed_ms = hist_in.last_considered_ms;
         push_count_in          = push_count_ff + 1'b1;
      end
   end

   always_comb begin
      result.decision    = cur_verdict;
      result.clear_dirty = 1'b0;
      result.frame_hash  = '0;
      result.push_total  = push_count_in;
      if (cur_verdict == VERDICT_PUSH) begin
         result.decision    = same_content ? VERDICT_SAME : VERDICT_PUSH;
         result.clear_dirty = 1'b1;
         result.frame_hash  = hash_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff   <= 1'b0;
         running_hash_ff   <= FNV_OFFSET;
         verdict_ff        <= VERDICT_PUSH;
         keep_alive_due_ff <= 1'b0;
         hist_ff           <= '0;
         last_hash_ff      <= '0;
         push_count_ff     <= '0;
      end else begin
         frame_active_ff   <= frame_active_in;
         running_hash_ff   <= running_hash_in;
         verdict_ff        <= verdict_in;
         keep_alive_due_ff <= keep_alive_due_in;
         hist_ff           <= hist_in;
         last_hash_ff      <= last_hash_in;
         push_count_ff     <= push_count_in;
      end
   end

endmodule

// ===== hw/rtl/frame_push_gate_fnv1a.sv =====
// Channel  Role    Handshake      Payload
// req_if   sink    valid / ready  pixel_byte, first_byte, last_byte, now_ms, canvas_dirty
// rsp_if   source  valid / ready  decision, clear_dirty, frame_hash, push_total
// csr_*    write   csr_write_en   csr_index, csr_data
//
// One byte transaction is taken per cycle while no last byte waits; a result is
// offered once the last byte has passed the input register and the result register.
// The rate is set by the single FNV-1a fold per byte, one constant multiply.
// Reset is synchronous and active high and clears all frame and push state.
// A stalled result holds the result register; bytes that produce no result
// keep flowing, and only a last byte waits for the result register to free.
module frame_push_gate_fnv1a (
   input  logic                              clock,
   input  logic                              reset,
   fpg_req_if.sink                           req_if,
   fpg_rsp_if.source                         rsp_if,
   input  logic                              csr_write_en,
   input  logic [fpg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fpg_pkg::CSR_DATA_W-1:0]    csr_data
);
   import fpg_pkg::*;

   cfg_type      cfg;

   // Input register: holds one byte transaction for the gate logic.
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;

   // Result register: holds one finished result until the sink takes it.
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic         emit;
   logic         out_space;
   logic         in_advance;
   logic         req_take;
   rsp_item_type result;

   fpg_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   fpg_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (in_item_ff),
      .step_en (in_advance),
      .emit    (emit),
      .result  (result)
   );

   // The held byte moves on unless it finishes a frame and the result
   // register is still occupied by a result nobody has taken.
   assign out_space  = !out_valid_ff || rsp_if.ready;
   assign in_advance = in_valid_ff && (!emit || out_space);
   assign req_take   = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || in_advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (in_advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in             = 1'b1;
         in_item_in.pixel_byte   = req_if.pixel_byte;
         in_item_in.first_byte   = req_if.first_byte;
         in_item_in.last_byte    = req_if.last_byte;
         in_item_in.now_ms       = req_if.now_ms;
         in_item_in.canvas_dirty = req_if.canvas_dirty;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (out_space) begin
         out_valid_in = in_advance && emit;
         out_item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.decision    = out_item_ff.decision;
   assign rsp_if.clear_dirty = out_item_ff.clear_dirty;
   assign rsp_if.frame_hash  = out_item_ff.frame_hash;
   assign rsp_if.push_total  = out_item_ff.push_total;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   import fpg_pkg::*;

   // FNV-1a constants of the frame hash, kept locally so the predictor does not
   // lean on the package for its arithmetic.
   localparam logic [31:0] HASH_SEED = 32'd2166136261;
   localparam logic [31:0] HASH_MULT = 32'd16777619;

   // Cycles to let pass after the last expected result before a register write.
   // A result is offered once its last byte has left the input register, so
   // this also covers bytes still in the input register that cause no result.
   localparam int unsigned DRAIN_PAUSE = 6;
   // Length of the long receiver hold-off used to fill the block up.
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned FINAL_WAIT_LIMIT = 5000;
   localparam int unsigned MAX_REPORTS = 10;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   fpg_req_if req ();
   fpg_rsp_if rsp ();

   frame_push_gate_fnv1a dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req),
      .rsp_if       (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state. This mirrors the block: the programmed registers, the
   // hash of the open frame, the verdict reached on its first byte, and the
   // history of considered and pushed frames.
   // ------------------------------------------------------------------------
   cfg_type      cfg_model;
   logic [31:0]  fold_hash;
   logic         in_frame;
   verdict_type  frame_call;
   logic         ka_due;
   logic [31:0]  last_seen_ms;
   logic         seen_once;
   logic [31:0]  last_push_ms;
   logic         has_pushed;
   logic [31:0]  last_push_hash;
   logic [31:0]  push_cnt;

   // Expected frame results, oldest first.
   rsp_item_type verdict_queue [$];

   // Stimulus knobs shared between the test tasks and the receiver process.
   int unsigned  sender_idle_pct;
   int unsigned  recv_stall_pct;
   int unsigned  hold_requests = 0;
   int unsigned  hold_served = 0;
   int unsigned  hold_left = 0;
   int unsigned  mismatch_count;

   // Running millisecond clock for the random frames, and a small pool of
   // frame contents that repeat, so identical hashes really occur.
   logic [31:0]  stamp;
   logic [31:0]  pool_seed [4];
   int unsigned  pool_len [4];

   function automatic void note_mismatch(input string msg);
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endfunction

   // Checks made on the first byte of a frame. They use the registers as they
   // stand now; later register writes do not touch the open frame.
   function automatic void judge_first_byte(input logic [31:0] now, input logic dirty);
      logic [31:0] since_push;
      logic [31:0] since_seen;
      logic        ka;
      ka_due = 1'b0;
      if (!cfg_model.sink_present) begin
         frame_call = VERDICT_NOSINK;
         return;
      end
      since_push = now - last_push_ms;
      since_seen = now - last_seen_ms;
      ka = has_pushed && (cfg_model.keep_alive_ms != 32'd0) &&
           (since_push >= cfg_model.keep_alive_ms);
      ka_due = ka;
      // The frame cap measures against the last frame considered, pushed or not.
      if (seen_once && (since_seen < cfg_model.min_frame_interval_ms)) begin
         frame_call = VERDICT_RATE;
         return;
      end
      last_seen_ms = now;
      seen_once = 1'b1;
      // Dirty gating is skipped in draw mode and when keep-alive is due.
      if (!cfg_model.draw_mode && has_pushed && !dirty && !ka) begin
         frame_call = VERDICT_CLEAN;
         return;
      end
      frame_call = VERDICT_PUSH;
   endfunction

   // Folds one accepted byte transaction into the predictor and queues the
   // frame result when the byte closes a frame.
   function automatic void fold_and_judge_byte(input req_item_type it);
      logic [31:0]  mixed;
      rsp_item_type want;
      if (it.first_byte) begin
         // A first byte always opens a new frame; an open one is dropped.
         in_frame = 1'b1;
         fold_hash = HASH_SEED;
         judge_first_byte(it.now_ms, it.canvas_dirty);
      end else if (!in_frame) begin
         return;
      end
      mixed = fold_hash ^ {24'd0, it.pixel_byte};
      fold_hash = mixed * HASH_MULT;
      if (!it.last_byte) begin
         return;
      end
      in_frame = 1'b0;
      want.decision = frame_call;
      want.clear_dirty = 1'b0;
      want.frame_hash = 32'd0;
      if (frame_call == VERDICT_PUSH) begin
         want.frame_hash = fold_hash;
         want.clear_dirty = 1'b1;
         if (has_pushed && (fold_hash == last_push_hash) && !ka_due) begin
            want.decision = VERDICT_SAME;
         end else begin
            // The push is stamped with the time sampled on its first byte.
            last_push_hash = fold_hash;
            last_push_ms = last_seen_ms;
            has_pushed = 1'b1;
            push_cnt = push_cnt + 32'd1;
         end
      end
      want.push_total = push_cnt;
      verdict_queue.push_back(want);
   endfunction

   // ------------------------------------------------------------------------
   // Driving. Inputs change on the falling edge; a transaction is taken on the
   // rising edge that sees valid and ready high, and only then does it enter
   // the predictor.
   // ------------------------------------------------------------------------
   task automatic send_byte(input req_item_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.pixel_byte = it.pixel_byte;
      req.first_byte = it.first_byte;
      req.last_byte = it.last_byte;
      req.now_ms = it.now_ms;
      req.canvas_dirty = it.canvas_dirty;
      @(posedge clock);
      while (req.ready !== 1'b1) begin
         @(posedge clock);
      end
      fold_and_judge_byte(it);
   endtask

   task automatic send_one(input logic [7:0] pixel, input logic first, input logic last,
                           input logic [31:0] now, input logic dirty);
      req_item_type it;
      it.pixel_byte = pixel;
      it.first_byte = first;
      it.last_byte = last;
      it.now_ms = now;
      it.canvas_dirty = dirty;
      send_byte(it);
   endtask

   function automatic logic [7:0] pool_byte(input logic [31:0] seed, input int unsigned k);
      logic [31:0] m;
      m = seed ^ (k * 32'h9E37_79B1);
      return m[7:0] ^ m[23:16];
   endfunction

   // Sends a frame of len bytes. Only the first byte carries the real time and
   // dirty flag; the rest carry noise there, which the block must ignore. An
   // incomplete frame has no last byte and is left open.
   task automatic send_frame(input int unsigned len, input logic [31:0] start_ms,
                             input logic dirty, input logic use_pool,
                             input logic [31:0] seed, input logic complete);
      logic [7:0] pixel;
      for (int unsigned k = 0; k < len; k++) begin
         pixel = use_pool ? pool_byte(seed, k) : 8'($urandom_range(0, 255));
         send_one(pixel, k == 0, complete && (k == len - 1),
                  (k == 0) ? start_ms : $urandom(),
                  (k == 0) ? dirty : ($urandom_range(0, 1) == 1));
      end
   endtask

   // Lowers valid and waits until every expected result is in and the block
   // has had time to settle, so that registers can be written safely.
   task automatic wait_drained();
      @(negedge clock);
      req.valid = 1'b0;
      while (verdict_queue.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (idx)
         CSR_SINK_PRESENT: cfg_model.sink_present = value[0];
         CSR_DRAW_MODE:    cfg_model.draw_mode = value[0];
         CSR_MIN_INTERVAL: cfg_model.min_frame_interval_ms = value;
         CSR_KEEP_ALIVE:   cfg_model.keep_alive_ms = value;
         default: ;
      endcase
   endtask

   // Interval values: often zero or the all-ones extreme, sometimes huge,
   // mostly on the scale of the time steps between random frames.
   function automatic logic [31:0] pick_span(input int unsigned short_top);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
         return 32'd0;
      end
      if (roll < 35) begin
         return 32'hFFFF_FFFF;
      end
      if (roll < 50) begin
         return $urandom();
      end
      return $urandom_range(1, short_top);
   endfunction

   task automatic program_random_cfg();
      write_reg(CSR_SINK_PRESENT, ($urandom_range(0, 9) != 0) ? 32'd1 : 32'd0);
      write_reg(CSR_DRAW_MODE, $urandom_range(0, 1));
      write_reg(CSR_MIN_INTERVAL, pick_span(40));
      write_reg(CSR_KEEP_ALIVE, pick_span(80));
      for (int i = 0; i < 4; i++) begin
         pool_seed[i] = $urandom();
         pool_len[i] = $urandom_range(1, 6);
      end
   endtask

   // ------------------------------------------------------------------------
   // Directed tests.
   // ------------------------------------------------------------------------

   // Without a sink every frame is a no-op, and a byte outside a frame is
   // dropped even when it carries the last mark.
   task automatic test_no_sink();
      write_reg(CSR_SINK_PRESENT, 32'd0);
      write_reg(CSR_DRAW_MODE, 32'd0);
      write_reg(CSR_MIN_INTERVAL, 32'd0);
      write_reg(CSR_KEEP_ALIVE, 32'd0);
      send_one(8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
      send_one(8'h00, 1'b0, 1'b1, 32'd0, 1'b0);
      wait_drained();
   endtask

   // First push happens even on a clean canvas; then the same content is
   // suppressed, a clean canvas is gated, new content pushes, and a frame cut
   // short by a new first byte gives no result.
   task automatic test_push_and_dedup();
      write_reg(CSR_SINK_PRESENT, 32'd1);
      send_one(8'h00, 1'b1, 1'b0, 32'd100, 1'b0);
      send_one(8'hFF, 1'b0, 1'b1, 32'd7, 1'b1);
      send_one(8'h00, 1'b1, 1'b0, 32'd110, 1'b1);
      send_one(8'hFF, 1'b0, 1'b1, 32'd9, 1'b0);
      send_one(8'h00, 1'b1, 1'b0, 32'd120, 1'b0);
      send_one(8'hFF, 1'b0, 1'b1, 32'd11, 1'b1);
      send_one(8'h5A, 1'b1, 1'b1, 32'd130, 1'b1);
      send_one(8'h11, 1'b1, 1'b0, 32'd140, 1'b1);
      send_one(8'h22, 1'b1, 1'b1, 32'd150, 1'b1);
      wait_drained();
   endtask

   // The frame cap: one frame too early, one exactly on the interval, then the
   // all-ones interval reached by a time step that wraps around.
   task automatic test_rate_limit();
      write_reg(CSR_MIN_INTERVAL, 32'd100);
      send_one(8'h33, 1'b1, 1'b1, 32'd200, 1'b1);
      send_one(8'h44, 1'b1, 1'b1, 32'd250, 1'b1);
      wait_drained();
      write_reg(CSR_MIN_INTERVAL, 32'hFFFF_FFFF);
      // The second byte carries a far later time; the push must be stamped
      // with the first byte's time, which the keep-alive test then relies on.
      send_one(8'h5A, 1'b1, 1'b0, 32'd249, 1'b1);
      send_one(8'hA5, 1'b0, 1'b1, 32'd5000, 1'b0);
      wait_drained();
   endtask

   // Keep-alive: not yet due keeps the clean gate, due forces a push of the
   // same content, and the all-ones setting never comes due.
   task automatic test_keep_alive();
      write_reg(CSR_MIN_INTERVAL, 32'd0);
      write_reg(CSR_KEEP_ALIVE, 32'd50);
      send_one(8'h5A, 1'b1, 1'b0, 32'd290, 1'b0);
      send_one(8'hA5, 1'b0, 1'b1, 32'd0, 1'b1);
      send_one(8'h5A, 1'b1, 1'b0, 32'd299, 1'b0);
      send_one(8'hA5, 1'b0, 1'b1, 32'd0, 1'b1);
      wait_drained();
      write_reg(CSR_KEEP_ALIVE, 32'hFFFF_FFFF);
      send_one(8'h5A, 1'b1, 1'b0, 32'd300, 1'b1);
      send_one(8'hA5, 1'b0, 1'b1, 32'd0, 1'b0);
      wait_drained();
   endtask

   // Draw mode ignores the dirty flag but still suppresses identical content.
   task automatic test_draw_mode();
      write_reg(CSR_KEEP_ALIVE, 32'd0);
      write_reg(CSR_DRAW_MODE, 32'd1);
      send_one(8'h77, 1'b1, 1'b1, 32'd310, 1'b0);
      send_one(8'h77, 1'b1, 1'b1, 32'd320, 1'b0);
      wait_drained();
   endtask

   // Registers written while a frame is open must not change its verdict.
   task automatic test_midframe_config();
      write_reg(CSR_DRAW_MODE, 32'd0);
      send_one(8'h99, 1'b1, 1'b0, 32'd330, 1'b1);
      wait_drained();
      write_reg(CSR_SINK_PRESENT, 32'd0);
      write_reg(CSR_DRAW_MODE, 32'd1);
      send_one(8'h66, 1'b0, 1'b1, 32'd0, 1'b0);
      wait_drained();
      stamp = 32'd330;
   endtask

   // ------------------------------------------------------------------------
   // Random traffic. Mostly complete frames, half of them from the repeating
   // pool, with some frames cut short and some stray bytes between frames.
   // Each phase is split into segments with a fresh register setting each.
   // ------------------------------------------------------------------------
   task automatic run_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned target);
      int unsigned sent;
      int unsigned next_cfg;
      int unsigned roll;
      int unsigned len;
      int unsigned slot;
      logic        dirty;
      sender_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      sent = 0;
      next_cfg = 0;
      while (sent < target) begin
         if (sent >= next_cfg) begin
            wait_drained();
            program_random_cfg();
            next_cfg = next_cfg + target / 4;
         end
         // Now and then a big jump, so time wraps around 2^32.
         stamp = stamp + (($urandom_range(0, 11) == 0) ? $urandom() : $urandom_range(0, 50));
         dirty = ($urandom_range(0, 2) != 0);
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            send_one(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 1) == 1,
                     $urandom(), $urandom_range(0, 1) == 1);
         end else if (roll < 14) begin
            len = $urandom_range(1, 4);
            send_frame(len, stamp, dirty, 1'b0, 32'd0, 1'b0);
            sent = sent + len;
         end else if (roll < 57) begin
            slot = $urandom_range(0, 3);
            send_frame(pool_len[slot], stamp, dirty, 1'b1, pool_seed[slot], 1'b1);
            sent = sent + pool_len[slot];
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            send_frame(len, stamp, dirty, 1'b0, 32'd0, 1'b1);
            sent = sent + len;
         end
      end
      wait_drained();
   endtask

   // The receiver holds off for a long stretch while short frames keep coming,
   // so the result register fills and the block stalls its input. Afterwards
   // the sender waits for every result before going on.
   task automatic test_backpressure();
      sender_idle_pct = 0;
      recv_stall_pct = 0;
      write_reg(CSR_SINK_PRESENT, 32'd1);
      write_reg(CSR_DRAW_MODE, 32'd1);
      write_reg(CSR_MIN_INTERVAL, 32'd0);
      write_reg(CSR_KEEP_ALIVE, 32'd0);
      hold_requests = hold_requests + 1;
      for (int i = 0; i < 40; i++) begin
         stamp = stamp + 32'd3;
         send_frame($urandom_range(1, 2), stamp, 1'b1, 1'b0, 32'd0, 1'b1);
      end
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // Receiver side. Ready changes on the falling edge: a requested hold-off is
   // counted out here, otherwise ready stalls at random at the phase's rate.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp.ready = 1'b0;
         hold_left = hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_served + 1;
         hold_left = HOLD_CYCLES - 1;
         rsp.ready = 1'b0;
      end else begin
         rsp.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Every result transaction is matched against the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (verdict_queue.size() == 0) begin
            note_mismatch($sformatf("unexpected result: decision %0d hash %h total %0d",
                                    rsp.decision, rsp.frame_hash, rsp.push_total));
         end else begin
            want = verdict_queue.pop_front();
            if (rsp.decision !== want.decision || rsp.clear_dirty !== want.clear_dirty ||
                rsp.frame_hash !== want.frame_hash || rsp.push_total !== want.push_total) begin
               note_mismatch($sformatf(
                  "mismatch exp/act: decision %0d/%0d clear %0b/%0b hash %h/%h total %0d/%0d",
                  want.decision, rsp.decision, want.clear_dirty, rsp.clear_dirty,
                  want.frame_hash, rsp.frame_hash, want.push_total, rsp.push_total));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      int unsigned wait_cycles;
      reset = 1'b1;
      req.valid = 1'b0;
      req.pixel_byte = '0;
      req.first_byte = 1'b0;
      req.last_byte = 1'b0;
      req.now_ms = '0;
      req.canvas_dirty = 1'b0;
      rsp.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      sender_idle_pct = 0;
      recv_stall_pct = 0;
      mismatch_count = 0;
      stamp = 32'd0;
      // Predictor starts from the reset state of the block.
      cfg_model = '0;
      fold_hash = HASH_SEED;
      in_frame = 1'b0;
      frame_call = VERDICT_PUSH;
      ka_due = 1'b0;
      last_seen_ms = 32'd0;
      seen_once = 1'b0;
      last_push_ms = 32'd0;
      has_pushed = 1'b0;
      last_push_hash = 32'd0;
      push_cnt = 32'd0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_no_sink();
      test_push_and_dedup();
      test_rate_limit();
      test_keep_alive();
      test_draw_mode();
      test_midframe_config();
      run_random_phase(0, 0, 300);
      run_random_phase(67, 0, 300);
      run_random_phase(0, 67, 300);
      run_random_phase(13, 13, 300);
      test_backpressure();

      // All stimulus is in; wait for the remaining results, then a little more
      // so that a stray extra result would still be seen.
      @(negedge clock);
      req.valid = 1'b0;
      wait_cycles = 0;
      while (verdict_queue.size() != 0 && wait_cycles < FINAL_WAIT_LIMIT) begin
         @(negedge clock);
         wait_cycles = wait_cycles + 1;
      end
      repeat (2 * DRAIN_PAUSE) @(negedge clock);
      if (verdict_queue.size() != 0) begin
         note_mismatch($sformatf("%0d expected results never arrived", verdict_queue.size()));
      end
      if (mismatch_count == 0) begin
         $display("frame_push_gate_fnv1a test passed");
      end else begin
         $display("frame_push_gate_fnv1a test failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("frame_push_gate_fnv1a test failed");
      $finish;
   end

endmodule
